// ----- rtl/pws_pkg.sv -----
// Shared types and constants for the polynomial waveshaper.
`default_nettype none

package pws_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 24;
  localparam int CFG_IDX_W     = 4;
  localparam int NUM_COEF_REGS = 7;
  localparam int REG_COUNT     = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DEG6 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DEG5 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DEG4 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DEG3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DEG2 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DEG1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_DEG0 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE = 4'd7;

  localparam logic [COEF_W-1:0] ONE_Q15 = 24'd32768;

  // Power chain in Q.30, products in Q.45
  localparam int POW_W   = 32;
  localparam int PX_W    = 48;
  localparam int TERM_W  = 56;
  localparam int ACC_W   = 57;
  localparam int Q24_W   = 36;
  localparam int HALF_W  = 18;
  localparam int PH_W    = 42;
  localparam int PL_W    = 43;
  localparam int WIDE_W  = 60;
  localparam int Q15_W   = 36;

  localparam logic signed [POW_W-1:0]  ONE_Q30  = 32'sd1073741824;
  localparam logic signed [PX_W-1:0]   RND_POW  = 48'sd16384;
  localparam logic signed [ACC_W-1:0]  RND_ACC  = 57'sd1048576;
  localparam logic signed [WIDE_W-1:0] RND_OUT  = 60'sd8388608;
  localparam logic signed [Q15_W-1:0]  OUT_MAX  = 36'sd32767;
  localparam logic signed [Q15_W-1:0]  OUT_MIN  = -36'sd32768;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic                       vld;
    logic signed [SAMPLE_W-1:0] x;
  } slot_t;

  // Coefficients indexed by degree
  typedef struct packed {
    logic [NUM_COEF_REGS-1:0][COEF_W-1:0] coef;
    logic [COEF_W-1:0]                    scale;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/pws_cfg_regs.sv -----
// Configuration register file: coefficients and output gain.
`default_nettype none

module pws_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pws_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [pws_pkg::COEF_W-1:0]    cfg_data_i,
  output pws_pkg::cfg_t                      cfg_o
);
  import pws_pkg::*;

  logic [COEF_W-1:0] regs_q [REG_COUNT];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_q[i] <= '0;
      end
      regs_q[REG_COEF_DEG1[2:0]] <= ONE_Q15;
      regs_q[REG_OUT_SCALE[2:0]] <= ONE_Q15;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(REG_COUNT))) begin
      regs_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // Degree d lives at register index (deg0 index - d)
  always_comb begin
    for (int d = 0; d < NUM_COEF_REGS; d++) begin
      cfg_o.coef[d] = regs_q[int'(REG_COEF_DEG0) - d];
    end
    cfg_o.scale = regs_q[REG_OUT_SCALE[2:0]];
  end

endmodule

`default_nettype wire

// ----- rtl/pws_queue.sv -----
// Input queue between the accepting front and the evaluation pipeline.
`default_nettype none

module pws_queue (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  output logic                                    ready_o,
  input  wire logic signed [pws_pkg::SAMPLE_W-1:0] x_i,
  output pws_pkg::slot_t                          slot_o,
  input  wire logic                               take_i
);
  import pws_pkg::*;

  logic signed [SAMPLE_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic push, pop;

  assign ready_o    = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign slot_o.vld = (count_q != '0);
  assign slot_o.x   = mem_q[rd_ptr_q];
  assign push       = push_i && ready_o;
  assign pop        = take_i && slot_o.vld;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= x_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop && count_q == '0) |=> slot_o.vld)
    else $error("transfer into empty queue not visible");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push && count_q == QCNT_W'(QUEUE_DEPTH)) |=> ready_o)
    else $error("queue stays full after pop");

endmodule

`default_nettype wire

// ----- rtl/pws_eval.sv -----
// Evaluation pipeline: power chain, term accumulation, gain, rounding, saturation.
`default_nettype none

module pws_eval #(
  parameter int NUM_COEFFS = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  pws_pkg::cfg_t                            cfg_i,
  input  pws_pkg::slot_t                           slot_i,
  output logic                                     take_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [pws_pkg::SAMPLE_W-1:0]      sample_out_o,
  output logic                                     clipped_o
);
  import pws_pkg::*;

  localparam int NP = (NUM_COEFFS > 1) ? NUM_COEFFS - 1 : 1;

  logic pipe_en;

  // Stage s output: term of degree s and sum of lower terms
  logic [NUM_COEFFS-1:0]      vld_q;
  logic signed [TERM_W-1:0]   prod_q [NUM_COEFFS];
  logic signed [ACC_W-1:0]    acc_q  [NUM_COEFFS];
  logic signed [POW_W-1:0]    pow_q  [NP];
  logic signed [SAMPLE_W-1:0] x_q    [NP];

  logic                       sum_vld_q, mul_vld_q, rnd_vld_q;
  logic signed [ACC_W-1:0]    sum_d;
  logic [Q24_W-1:0]           q24_q;
  logic signed [PH_W-1:0]     ph_q;
  logic signed [PL_W-1:0]     pl_q;
  logic signed [WIDE_W-1:0]   full_d;
  logic signed [Q15_W-1:0]    q15_q;

  logic                       out_vld_q, clip_q;
  logic signed [SAMPLE_W-1:0] out_q;

  assign pipe_en = !out_vld_q || out_ready_i;
  assign take_o  = pipe_en;

  for (genvar s = 0; s < NUM_COEFFS; s++) begin : g_stage
    logic signed [POW_W-1:0]  pw;
    logic signed [ACC_W-1:0]  ac;
    logic signed [TERM_W-1:0] pr;
    logic signed [TERM_W-1:0] term;
    logic                     v;

    if (s == 0) begin : g_head
      assign pw = ONE_Q30;
      assign ac = '0;
      assign pr = '0;
      assign v  = slot_i.vld;
    end else begin : g_body
      assign pw = pow_q[s-1];
      assign ac = acc_q[s-1];
      assign pr = prod_q[s-1];
      assign v  = vld_q[s-1];
    end

    assign term = $signed(cfg_i.coef[s]) * pw;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (pipe_en) begin
        vld_q[s] <= v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        prod_q[s] <= term;
        acc_q[s]  <= ac + ACC_W'(pr);
      end
    end

    // Next power, rounded back to Q.30
    if (s < NUM_COEFFS - 1) begin : g_pow
      logic signed [SAMPLE_W-1:0] xs;
      logic signed [PX_W-1:0]     px;

      if (s == 0) begin : g_xin
        assign xs = slot_i.x;
      end else begin : g_xpipe
        assign xs = x_q[s-1];
      end

      assign px = pw * xs + RND_POW;

      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          pow_q[s] <= px[POW_W+14:15];
          x_q[s]   <= xs;
        end
      end
    end
  end

  assign sum_d  = acc_q[NUM_COEFFS-1] + ACC_W'(prod_q[NUM_COEFFS-1]) + RND_ACC;
  assign full_d = (WIDE_W'(ph_q) <<< HALF_W) + WIDE_W'(pl_q) + RND_OUT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      rnd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      sum_vld_q <= vld_q[NUM_COEFFS-1];
      mul_vld_q <= sum_vld_q;
      rnd_vld_q <= mul_vld_q;
      out_vld_q <= rnd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      q24_q <= sum_d[ACC_W-1:21];
      // Gain split into signed high and unsigned low halves of the Q.24 value
      ph_q  <= $signed(q24_q[Q24_W-1:HALF_W]) * $signed(cfg_i.scale);
      pl_q  <= $signed({1'b0, q24_q[HALF_W-1:0]}) * $signed(cfg_i.scale);
      q15_q <= full_d[WIDE_W-1:24];
      if (q15_q > OUT_MAX) begin
        out_q  <= OUT_MAX[SAMPLE_W-1:0];
        clip_q <= 1'b1;
      end else if (q15_q < OUT_MIN) begin
        out_q  <= OUT_MIN[SAMPLE_W-1:0];
        clip_q <= 1'b1;
      end else begin
        out_q  <= q15_q[SAMPLE_W-1:0];
        clip_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = out_q;
  assign clipped_o    = clip_q;

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q) && $stable(rnd_vld_q))
    else $error("pipeline moved while stalled");

  a_clip_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && clip_q) |->
      (out_q == OUT_MAX[SAMPLE_W-1:0] || out_q == OUT_MIN[SAMPLE_W-1:0]))
    else $error("clipped result not at a rail");

  a_tail_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && mul_vld_q) |=> rnd_vld_q)
    else $error("lost item in gain stage");

endmodule

`default_nettype wire

// ----- rtl/polynomial_waveshaper_unit.sv -----
// Top level of the polynomial waveshaper: input queue, config registers, evaluator.
// Throughput: one sample per cycle while the output is not stalled; one power/term stage per
// coefficient plus four tail stages (sum rounding, gain multiply, gain rounding, saturation).
// A two-entry input queue lets the front take samples while the output register is stalled.
// Reset (async, active low) empties the queue and pipeline; coefficients reset to identity.
`default_nettype none

module polynomial_waveshaper_unit #(
  parameter int NUM_COEFFS = 7
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [pws_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [pws_pkg::COEF_W-1:0]           cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [pws_pkg::SAMPLE_W-1:0]  sample_in_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [pws_pkg::SAMPLE_W-1:0]       sample_out_o,
  output logic                                      clipped_o
);
  import pws_pkg::*;

  cfg_t  cfg;
  slot_t slot;
  logic  take;

  pws_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .ready_o (in_ready_o),
    .x_i     (sample_in_i),
    .slot_o  (slot),
    .take_i  (take)
  );

  pws_eval #(
    .NUM_COEFFS (NUM_COEFFS)
  ) u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .slot_i       (slot),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

`default_nettype wire
